// ===== rtl/core/wdlm_pkg.sv =====
// shared types, constants and character helpers for the word diff letter marker
package wdlm_pkg;

    localparam int MAX_LEN   = 32;
    localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int PCT_W     = 7;
    localparam int PROD_W    = LEN_W + PCT_W;

    localparam logic [LEN_W-1:0] MAX_LEN_L    = LEN_W'(MAX_LEN);
    localparam logic [PCT_W-1:0] PCT_RESET    = 7'd60;
    localparam logic [PCT_W-1:0] PCT_SCALE    = 7'd100;

    localparam logic [1:0] REQ_LOAD_CORRECT = 2'd0;
    localparam logic [1:0] REQ_LOAD_GIVEN   = 2'd1;
    localparam logic [1:0] REQ_COMPARE      = 2'd2;

    localparam logic [1:0] LS_CORRECT = 2'd0;
    localparam logic [1:0] LS_WRONG   = 2'd1;
    localparam logic [1:0] LS_MISSING = 2'd2;

    localparam logic [1:0] WS_CORRECT     = 2'd0;
    localparam logic [1:0] WS_ALL_WRONG   = 2'd1;
    localparam logic [1:0] WS_ALL_MISSING = 2'd2;
    localparam logic [1:0] WS_MIXED       = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
    } wdlm_in_t;

    typedef struct packed {
        logic       has_letter;
        logic [7:0] out_char;
        logic [1:0] letter_state;
        logic       last;
        logic [1:0] word_state;
        logic       punc_error;
        logic       cap_error;
        logic       spelling_error;
        logic       other_error;
    } wdlm_out_t;

    function automatic logic [7:0] to_low(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_punc(input logic [7:0] c);
        logic r;
        case (c) inside
            8'h21, 8'h22, 8'h23, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h2A, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3F,
            8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h5F, 8'h7B, 8'h7D: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/word_diff_letter_marker_core.sv =====
// word diff letter marker: word stores, alignment sequencer and result staging
//
// s_ channel: one beat per request. req_type 0 appends char_code to the
// correct word, 1 appends it to the given word, 2 compares the two words and
// 3 is dropped. Characters past MAX_LEN are dropped.
// m_ channel: a compare yields one beat per marked letter, or a single empty
// beat when both words are empty; the beat with last set carries the word
// state and error flags. Both words are cleared once that beat is issued.
// cfg_wr_en/cfg_wr_data write the spelling percentage (reset 60).
// A compare runs on one sequencer over single-port reads of each store: an
// equality pass, then a walk that emits the letters, with look-ahead
// searches through the words on each mismatch. s_ready is low from
// the compare beat until the final beat has entered the output register.
// Results are held one beat back so that the final one can carry the flags;
// a stall on m_ready holds the sequencer at its next emit step, nothing lost.
// Reset (aresetn low, synchronous) empties both words and the output.
module word_diff_letter_marker_core
    import wdlm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  wdlm_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output wdlm_out_t        m_data,
    input  logic             cfg_wr_en,
    input  logic [PCT_W-1:0] cfg_wr_data
);

    typedef enum logic [18:0] {
        ST_IDLE     = 19'd1 << 0,
        ST_EQ_ISSUE = 19'd1 << 1,
        ST_EQ_CMP   = 19'd1 << 2,
        ST_CLASS    = 19'd1 << 3,
        ST_G_ISSUE  = 19'd1 << 4,
        ST_G_CMP    = 19'd1 << 5,
        ST_G_EQ     = 19'd1 << 6,
        ST_G_CAP1   = 19'd1 << 7,
        ST_G_CAP2   = 19'd1 << 8,
        ST_S1_ISSUE = 19'd1 << 9,
        ST_S1_CMP   = 19'd1 << 10,
        ST_S2_ISSUE = 19'd1 << 11,
        ST_S2_CMP   = 19'd1 << 12,
        ST_DECIDE   = 19'd1 << 13,
        ST_TC_ISSUE = 19'd1 << 14,
        ST_TC_EMIT  = 19'd1 << 15,
        ST_TG_ISSUE = 19'd1 << 16,
        ST_TG_EMIT  = 19'd1 << 17,
        ST_FIN      = 19'd1 << 18
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] correct_mem [MAX_LEN];
    logic [7:0] given_mem   [MAX_LEN];

    logic [LEN_W-1:0] c_len_reg, g_len_reg;
    logic [LEN_W-1:0] a_reg, b_reg, i_reg, j_reg;
    logic [LEN_W-1:0] common_reg;
    logic [PCT_W-1:0] pct_reg;
    logic [7:0]       c_rdata_reg, g_rdata_reg, cc_reg, gg_reg;
    logic             punc_reg, cap_reg, nonpunc_reg, eq_reg, general_reg;
    logic [1:0]       ws_reg, tail_state_reg;
    wdlm_out_t        pend_reg, m_data_reg;
    logic             pend_valid_reg, m_valid_reg;

    logic              s_fire, out_free, emit_req, emit_go, emit_flag, fin_go, c_adv;
    logic              c_ren, g_ren;
    logic [ADDR_W-1:0] c_raddr, g_raddr;
    logic [7:0]        emit_char;
    logic [1:0]        emit_state;
    logic [LEN_W-1:0]  d1, d2, longer;
    logic [PROD_W-1:0] thr_lhs, thr_rhs;
    wdlm_out_t         emit_rec, fin_rec;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign emit_go  = emit_req && out_free;
    assign fin_go   = (state_reg == ST_FIN) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign d1     = i_reg - a_reg;
    assign d2     = j_reg - b_reg;
    assign c_adv  = (i_reg != c_len_reg) && ((j_reg == g_len_reg) || (d1 < d2));
    assign longer = (c_len_reg > g_len_reg) ? c_len_reg : g_len_reg;
    assign thr_lhs = PROD_W'(common_reg) * PROD_W'(PCT_SCALE);
    assign thr_rhs = PROD_W'(pct_reg) * PROD_W'(longer);

    // read port selection
    always_comb begin
        c_ren   = 1'b0;
        g_ren   = 1'b0;
        c_raddr = a_reg[ADDR_W-1:0];
        g_raddr = b_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_EQ_ISSUE: begin
                c_ren = (c_len_reg == g_len_reg) && (a_reg != c_len_reg);
                g_ren = c_ren;
                g_raddr = a_reg[ADDR_W-1:0];
            end
            ST_G_ISSUE: begin
                c_ren = (a_reg != c_len_reg) && (b_reg != g_len_reg);
                g_ren = c_ren;
            end
            ST_S1_ISSUE: begin
                c_ren   = (i_reg != c_len_reg);
                c_raddr = i_reg[ADDR_W-1:0];
            end
            ST_S2_ISSUE: begin
                g_ren   = (j_reg != g_len_reg);
                g_raddr = j_reg[ADDR_W-1:0];
            end
            ST_TC_ISSUE: c_ren = (a_reg != c_len_reg);
            ST_TG_ISSUE: g_ren = (b_reg != g_len_reg);
            default: ;
        endcase
    end

    // result selection
    always_comb begin
        emit_req   = 1'b0;
        emit_flag  = 1'b0;
        emit_char  = cc_reg;
        emit_state = LS_CORRECT;
        unique case (state_reg)
            ST_G_EQ: emit_req = 1'b1;
            ST_G_CAP1: begin
                emit_req   = 1'b1;
                emit_char  = gg_reg;
                emit_state = LS_WRONG;
            end
            ST_G_CAP2: begin
                emit_req   = 1'b1;
                emit_state = LS_MISSING;
            end
            ST_DECIDE: begin
                emit_req   = 1'b1;
                emit_flag  = 1'b1;
                emit_char  = c_adv ? cc_reg : gg_reg;
                emit_state = c_adv ? LS_MISSING : LS_WRONG;
            end
            ST_TC_EMIT: begin
                emit_req   = 1'b1;
                emit_flag  = (tail_state_reg != LS_CORRECT);
                emit_char  = c_rdata_reg;
                emit_state = tail_state_reg;
            end
            ST_TG_EMIT: begin
                emit_req   = 1'b1;
                emit_flag  = 1'b1;
                emit_char  = g_rdata_reg;
                emit_state = LS_WRONG;
            end
            default: ;
        endcase
    end

    always_comb begin
        emit_rec              = '0;
        emit_rec.has_letter   = 1'b1;
        emit_rec.out_char     = emit_char;
        emit_rec.letter_state = emit_state;

        fin_rec                = pend_valid_reg ? pend_reg : '0;
        fin_rec.last           = 1'b1;
        fin_rec.word_state     = ws_reg;
        fin_rec.punc_error     = punc_reg;
        fin_rec.cap_error      = cap_reg;
        fin_rec.spelling_error = general_reg && nonpunc_reg && (thr_lhs > thr_rhs);
        fin_rec.other_error    = nonpunc_reg && !(general_reg && (thr_lhs > thr_rhs));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_fire && s_data.req_type == REQ_COMPARE) begin
                    state_next = ST_EQ_ISSUE;
                end
            ST_EQ_ISSUE:
                if (c_len_reg != g_len_reg || a_reg == c_len_reg) begin
                    state_next = ST_CLASS;
                end else begin
                    state_next = ST_EQ_CMP;
                end
            ST_EQ_CMP:
                state_next = (c_rdata_reg == g_rdata_reg) ? ST_EQ_ISSUE : ST_CLASS;
            ST_CLASS:
                if (eq_reg || c_len_reg == '0 || g_len_reg == '0) begin
                    state_next = ST_TC_ISSUE;
                end else begin
                    state_next = ST_G_ISSUE;
                end
            ST_G_ISSUE:
                state_next = c_ren ? ST_G_CMP : ST_TC_ISSUE;
            ST_G_CMP:
                if (c_rdata_reg == g_rdata_reg) begin
                    state_next = ST_G_EQ;
                end else if (to_low(c_rdata_reg) == to_low(g_rdata_reg)) begin
                    state_next = ST_G_CAP1;
                end else begin
                    state_next = ST_S1_ISSUE;
                end
            ST_G_EQ:     if (emit_go) state_next = ST_G_ISSUE;
            ST_G_CAP1:   if (emit_go) state_next = ST_G_CAP2;
            ST_G_CAP2:   if (emit_go) state_next = ST_G_ISSUE;
            ST_S1_ISSUE: state_next = c_ren ? ST_S1_CMP : ST_S2_ISSUE;
            ST_S1_CMP:
                state_next = (to_low(c_rdata_reg) == to_low(gg_reg)) ? ST_S2_ISSUE
                                                                      : ST_S1_ISSUE;
            ST_S2_ISSUE: state_next = g_ren ? ST_S2_CMP : ST_DECIDE;
            ST_S2_CMP:
                state_next = (to_low(g_rdata_reg) == to_low(cc_reg)) ? ST_DECIDE
                                                                      : ST_S2_ISSUE;
            ST_DECIDE:   if (emit_go) state_next = ST_G_ISSUE;
            ST_TC_ISSUE: state_next = c_ren ? ST_TC_EMIT : ST_TG_ISSUE;
            ST_TC_EMIT:  if (emit_go) state_next = ST_TC_ISSUE;
            ST_TG_ISSUE: state_next = g_ren ? ST_TG_EMIT : ST_FIN;
            ST_TG_EMIT:  if (emit_go) state_next = ST_TG_ISSUE;
            ST_FIN:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // word stores
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.req_type == REQ_LOAD_CORRECT && c_len_reg < MAX_LEN_L) begin
            correct_mem[c_len_reg[ADDR_W-1:0]] <= s_data.char_code;
        end
        if (s_fire && s_data.req_type == REQ_LOAD_GIVEN && g_len_reg < MAX_LEN_L) begin
            given_mem[g_len_reg[ADDR_W-1:0]] <= s_data.char_code;
        end
        if (c_ren) begin
            c_rdata_reg <= correct_mem[c_raddr];
        end
        if (g_ren) begin
            g_rdata_reg <= given_mem[g_raddr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_G_CMP) begin
            cc_reg <= c_rdata_reg;
            gg_reg <= g_rdata_reg;
        end
        if (emit_go) begin
            pend_reg <= emit_rec;
            if (pend_valid_reg) begin
                m_data_reg <= pend_reg;
            end
        end
        if (fin_go) begin
            m_data_reg <= fin_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            c_len_reg      <= '0;
            g_len_reg      <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            common_reg     <= '0;
            pct_reg        <= PCT_RESET;
            punc_reg       <= 1'b0;
            cap_reg        <= 1'b0;
            nonpunc_reg    <= 1'b0;
            eq_reg         <= 1'b0;
            general_reg    <= 1'b0;
            ws_reg         <= WS_CORRECT;
            tail_state_reg <= LS_CORRECT;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                pct_reg <= cfg_wr_data;
            end

            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit_go) begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg) begin
                    m_valid_reg <= 1'b1;
                end
            end
            if (emit_go && emit_flag) begin
                if (is_punc(emit_char)) begin
                    punc_reg <= 1'b1;
                end else begin
                    nonpunc_reg <= 1'b1;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                    if (s_fire) begin
                        case (s_data.req_type)
                            REQ_LOAD_CORRECT:
                                if (c_len_reg < MAX_LEN_L) c_len_reg <= c_len_reg + 1'b1;
                            REQ_LOAD_GIVEN:
                                if (g_len_reg < MAX_LEN_L) g_len_reg <= g_len_reg + 1'b1;
                            REQ_COMPARE: begin
                                a_reg       <= '0;
                                b_reg       <= '0;
                                common_reg  <= '0;
                                punc_reg    <= 1'b0;
                                cap_reg     <= 1'b0;
                                nonpunc_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                ST_EQ_ISSUE:
                    if (state_next == ST_CLASS) begin
                        eq_reg <= (c_len_reg == g_len_reg);
                    end
                ST_EQ_CMP:
                    if (c_rdata_reg == g_rdata_reg) begin
                        a_reg <= a_reg + 1'b1;
                    end else begin
                        eq_reg <= 1'b0;
                    end
                ST_CLASS: begin
                    a_reg <= '0;
                    b_reg <= eq_reg ? g_len_reg : '0;
                    general_reg <= 1'b0;
                    tail_state_reg <= LS_MISSING;
                    if (eq_reg) begin
                        ws_reg         <= WS_CORRECT;
                        tail_state_reg <= LS_CORRECT;
                    end else if (c_len_reg == '0) begin
                        ws_reg <= WS_ALL_WRONG;
                    end else if (g_len_reg == '0) begin
                        ws_reg <= WS_ALL_MISSING;
                    end else begin
                        ws_reg      <= WS_MIXED;
                        general_reg <= 1'b1;
                    end
                end
                ST_G_CMP: begin
                    i_reg <= a_reg;
                    j_reg <= b_reg;
                end
                ST_G_EQ, ST_G_CAP2:
                    if (emit_go) begin
                        a_reg      <= a_reg + 1'b1;
                        b_reg      <= b_reg + 1'b1;
                        common_reg <= common_reg + 1'b1;
                    end
                ST_G_CAP1:
                    if (emit_go) cap_reg <= 1'b1;
                ST_S1_CMP:
                    if (to_low(c_rdata_reg) != to_low(gg_reg)) i_reg <= i_reg + 1'b1;
                ST_S2_CMP:
                    if (to_low(g_rdata_reg) != to_low(cc_reg)) j_reg <= j_reg + 1'b1;
                ST_DECIDE:
                    if (emit_go) begin
                        if (c_adv) begin
                            a_reg <= a_reg + 1'b1;
                        end else begin
                            b_reg <= b_reg + 1'b1;
                        end
                    end
                ST_TC_EMIT:
                    if (emit_go) a_reg <= a_reg + 1'b1;
                ST_TG_EMIT:
                    if (emit_go) b_reg <= b_reg + 1'b1;
                ST_FIN:
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        c_len_reg      <= '0;
                        g_len_reg      <= '0;
                    end
                default: ;
            endcase
        end
    end

    // word lengths never pass the store depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_len_reg <= MAX_LEN_L && g_len_reg <= MAX_LEN_L)
        else $error("word length beyond store depth");

    // no held-back beat survives into idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("pending beat left behind after compare");

    // walk pointers stay inside their words during a compare
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> (a_reg <= c_len_reg && b_reg <= g_len_reg))
        else $error("alignment pointer past end of word");

    // the correct-word search pointer never runs behind its alignment pointer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_S1_CMP || state_reg == ST_DECIDE) |-> i_reg >= a_reg)
        else $error("search pointer behind alignment pointer");

    // finishing a compare always puts the last beat on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> (m_valid_reg && m_data_reg.last && state_reg == ST_IDLE))
        else $error("final beat missing after compare");

endmodule
